@@ rtl/core/assert_macros.svh @@
// --------------------------------------------------------------------------
// assertion macros
// clocked assertion helpers used by the checker file
// --------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on clk, disabled while rst_n is low
`define ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication on clk, disabled while rst_n is low
`define ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/sdgm_pkg.sv @@
// --------------------------------------------------------------------------
// sdgm_pkg
// shared types and constants of the gradient map unit
// --------------------------------------------------------------------------
package sdgm_pkg;

    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [10:0] IMAGE_WIDTH_RESET  = 11'd640;
    localparam logic [12:0] IMAGE_HEIGHT_RESET = 13'd480;
    localparam logic [12:0] MAX_HEIGHT         = 13'd4096;

    localparam logic [15:0] ANGLE_FULL   = 16'd23040;
    localparam logic [4:0]  CORDIC_LAST  = 5'd19;
    localparam logic [4:0]  SQRT_STEPS   = 5'd16;
    localparam logic signed [23:0] Z_MAX = 24'sd5898240;

    typedef struct packed {
        logic [15:0]        mag;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_x;
    } grad_result_t;

    typedef struct packed {
        logic               start;
        logic signed [8:0]  gx;
        logic signed [8:0]  gy;
    } grad_req_t;

    function automatic logic [22:0] atan_entry(input logic [4:0] i);
        logic [22:0] v;
        case (i)
            5'd0:  v = 23'd2949120;
            5'd1:  v = 23'd1740967;
            5'd2:  v = 23'd919879;
            5'd3:  v = 23'd466945;
            5'd4:  v = 23'd234379;
            5'd5:  v = 23'd117304;
            5'd6:  v = 23'd58666;
            5'd7:  v = 23'd29335;
            5'd8:  v = 23'd14668;
            5'd9:  v = 23'd7334;
            5'd10: v = 23'd3667;
            5'd11: v = 23'd1833;
            5'd12: v = 23'd917;
            5'd13: v = 23'd458;
            5'd14: v = 23'd229;
            5'd15: v = 23'd115;
            5'd16: v = 23'd57;
            5'd17: v = 23'd29;
            5'd18: v = 23'd14;
            5'd19: v = 23'd7;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/sdgm_ram.sv @@
// --------------------------------------------------------------------------
// sdgm_ram
// simple dual-port ram, one write port and one registered read port
// --------------------------------------------------------------------------
module sdgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/sdgm_grad.sv @@
// --------------------------------------------------------------------------
// sdgm_grad
// iterative magnitude and angle unit for one difference pair
// --------------------------------------------------------------------------
module sdgm_grad
    import sdgm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  grad_req_t    req,
    output logic         done,
    output grad_result_t result
);

    typedef enum logic [1:0] {G_IDLE, G_SQUARE, G_RUN, G_FINISH} gstate_t;

    gstate_t            state_reg;
    logic [4:0]         cnt_reg;
    logic [7:0]         a_reg, b_reg;
    logic               neg_reg;
    logic [31:0]        rad_reg;
    logic [17:0]        rem_reg;
    logic [15:0]        root_reg;
    logic signed [31:0] x_reg, y_reg;
    logic signed [23:0] z_reg;
    logic               done_reg;
    grad_result_t       result_reg;

    logic signed [8:0]  gx_fix, gy_fix;
    logic [16:0]        sq_sum;
    logic signed [31:0] xs, ys;
    logic [19:0]        rem_try, trial;
    logic signed [23:0] z_clamp;
    logic [15:0]        ang;

    always_comb
    begin
        gx_fix  = (req.gx == 9'sd0) ? 9'sd1 : req.gx;
        gy_fix  = (req.gy == 9'sd0) ? 9'sd1 : req.gy;
        sq_sum  = 17'(a_reg * a_reg) + 17'(b_reg * b_reg);
        xs      = x_reg >>> cnt_reg;
        ys      = y_reg[31] ? -((-y_reg) >>> cnt_reg) : (y_reg >>> cnt_reg);
        rem_try = {rem_reg, rad_reg[31:30]};
        trial   = {2'b00, root_reg, 2'b01};
        if (z_reg < 24'sd0)
            z_clamp = 24'sd0;
        else if (z_reg > Z_MAX)
            z_clamp = Z_MAX;
        else
            z_clamp = z_reg;
        ang = 16'((z_clamp + 24'sd128) >>> 8);
        if (ang > ANGLE_FULL)
            ang = ANGLE_FULL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= G_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                G_IDLE:
                begin
                    if (req.start)
                    begin
                        a_reg     <= gx_fix[8] ? 8'(-gx_fix) : gx_fix[7:0];
                        b_reg     <= gy_fix[8] ? 8'(-gy_fix) : gy_fix[7:0];
                        neg_reg   <= gx_fix[8] ^ gy_fix[8];
                        state_reg <= G_SQUARE;
                    end
                end
                G_SQUARE:
                begin
                    rad_reg   <= {1'b0, sq_sum, 14'b0};
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    x_reg     <= {4'b0, a_reg, 20'b0};
                    y_reg     <= {4'b0, b_reg, 20'b0};
                    z_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= G_RUN;
                end
                G_RUN:
                begin
                    if (!y_reg[31])
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + $signed({1'b0, atan_entry(cnt_reg)});
                    end
                    else
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - $signed({1'b0, atan_entry(cnt_reg)});
                    end
                    if (cnt_reg < SQRT_STEPS)
                    begin
                        rad_reg <= {rad_reg[29:0], 2'b00};
                        if (rem_try >= trial)
                        begin
                            rem_reg  <= 18'(rem_try - trial);
                            root_reg <= {root_reg[14:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg  <= rem_try[17:0];
                            root_reg <= {root_reg[14:0], 1'b0};
                        end
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == CORDIC_LAST)
                        state_reg <= G_FINISH;
                end
                G_FINISH:
                begin
                    result_reg.mag     <= root_reg;
                    result_reg.angle_y <= neg_reg ? -$signed(ang) : $signed(ang);
                    result_reg.angle_x <= neg_reg ? -$signed(ANGLE_FULL - ang)
                                                  : $signed(ANGLE_FULL - ang);
                    done_reg  <= 1'b1;
                    state_reg <= G_IDLE;
                end
                default: state_reg <= G_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ rtl/core/straight_diagonal_gradient_map_unit.sv @@
// --------------------------------------------------------------------------
// straight_diagonal_gradient_map_unit
// 3x3 straight and diagonal gradient magnitude and orientation map
// --------------------------------------------------------------------------
// Pixels are taken one at a time. A pixel on the frame border goes through
// accept with line store read, then window update and write-back; an
// interior pixel goes on from there through the squaring step, 20 angle
// steps with the 16 root steps running inside them, the result latch and
// the hand-off to the output register, with both gradient units running
// side by side. A result waits in the output register while the next pixel
// is already taken; the next result stalls the input until the waiting one
// is transferred. Line stores are not cleared: the first two rows of a frame
// fill them before any result uses them. Output position is one row and one
// column behind the input pixel.
// --------------------------------------------------------------------------
module straight_diagonal_gradient_map_unit
    import sdgm_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [12:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // pixel
    input  logic         s_tuser,   // frame_start
    output logic         m_tvalid,
    input  logic         m_tready,
    // center_row, center_col, straight_mag, straight_angle_y, straight_angle_x,
    // diag_mag, diag_angle_y, diag_angle_x, zero fill
    output logic [119:0] m_tdata
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);

    typedef enum logic [1:0] {T_IDLE, T_READ, T_CALC, T_HOLD} tstate_t;

    tstate_t       state_reg;
    logic [10:0]   width_reg;
    logic [12:0]   height_reg;
    logic [CW-1:0] col_reg, col_next, c_reg, c_cur;
    logic [11:0]   row_reg, row_next, r_reg;
    logic [12:0]   r_cur;
    logic [7:0]    px_reg;
    logic [7:0]    win_reg [3][3];
    logic          m_valid_reg;
    logic [119:0]  m_data_reg;

    logic [12:0]   w13, h13, rn13;
    logic [CW-1:0] w_used, c_start, cn;
    logic [7:0]    upper_q, middle_q;
    logic          accept, interior;
    grad_req_t     sreq, dreq;
    logic          s_done, d_done;
    grad_result_t  sres, dres;
    logic [CW-1:0] cm1;
    logic [CW+9:0] cm1_ext;

    always_comb
    begin
        if (width_reg < 11'd3)
            w13 = 13'd3;
        else if ({2'b00, width_reg} > 13'(MAX_WIDTH))
            w13 = 13'(MAX_WIDTH);
        else
            w13 = {2'b00, width_reg};
        if (height_reg < 13'd3)
            h13 = 13'd3;
        else if (height_reg > MAX_HEIGHT)
            h13 = MAX_HEIGHT;
        else
            h13 = height_reg;
        w_used = w13[CW-1:0];

        c_start = s_tuser ? '0 : col_reg;
        r_cur   = s_tuser ? '0 : {1'b0, row_reg};
        if (c_start >= w_used)
        begin
            c_cur = '0;
            r_cur = r_cur + 13'd1;
        end
        else
        begin
            c_cur = c_start;
        end
        if (r_cur >= h13)
            r_cur = '0;

        cn   = c_cur + 1'b1;
        rn13 = r_cur;
        if (cn >= w_used)
        begin
            cn   = '0;
            rn13 = r_cur + 13'd1;
            if (rn13 >= h13)
                rn13 = '0;
        end
        col_next = cn;
        row_next = rn13[11:0];
    end

    assign s_tready = (state_reg == T_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign interior = (r_reg >= 12'd2) && (c_reg >= CW'(2));

    always_comb
    begin
        sreq.start = (state_reg == T_READ) && interior;
        sreq.gx    = $signed({1'b0, middle_q}) - $signed({1'b0, win_reg[1][1]});
        sreq.gy    = $signed({1'b0, win_reg[2][2]}) - $signed({1'b0, win_reg[0][2]});
        dreq.start = sreq.start;
        dreq.gx    = $signed({1'b0, px_reg}) - $signed({1'b0, win_reg[0][1]});
        dreq.gy    = $signed({1'b0, upper_q}) - $signed({1'b0, win_reg[2][1]});
        cm1        = c_reg - 1'b1;
        cm1_ext    = {10'b0, cm1};
    end

    sdgm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_upper (
        .clk     (clk),
        .wr_en   (state_reg == T_READ),
        .wr_addr (c_reg[AW-1:0]),
        .wr_data (middle_q),
        .rd_en   (accept),
        .rd_addr (c_cur[AW-1:0]),
        .rd_data (upper_q)
    );

    sdgm_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_middle (
        .clk     (clk),
        .wr_en   (state_reg == T_READ),
        .wr_addr (c_reg[AW-1:0]),
        .wr_data (px_reg),
        .rd_en   (accept),
        .rd_addr (c_cur[AW-1:0]),
        .rd_data (middle_q)
    );

    sdgm_grad u_straight (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (sreq),
        .done   (s_done),
        .result (sres)
    );

    sdgm_grad u_diag (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (dreq),
        .done   (d_done),
        .result (dres)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= T_IDLE;
            width_reg   <= IMAGE_WIDTH_RESET;
            height_reg  <= IMAGE_HEIGHT_RESET;
            col_reg     <= '0;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[k][j] <= '0;
                end
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg  <= cfg_wr_data[10:0];
                    CFG_IMAGE_HEIGHT: height_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (m_valid_reg && m_tready && (state_reg != T_HOLD))
                m_valid_reg <= 1'b0;
            unique case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                    begin
                        px_reg    <= s_tdata;
                        c_reg     <= c_cur;
                        r_reg     <= r_cur[11:0];
                        col_reg   <= col_next;
                        row_reg   <= row_next;
                        state_reg <= T_READ;
                    end
                end
                T_READ:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        win_reg[k][0] <= win_reg[k][1];
                        win_reg[k][1] <= win_reg[k][2];
                    end
                    win_reg[0][2] <= upper_q;
                    win_reg[1][2] <= middle_q;
                    win_reg[2][2] <= px_reg;
                    state_reg     <= interior ? T_CALC : T_IDLE;
                end
                T_CALC:
                begin
                    if (s_done && d_done)
                        state_reg <= T_HOLD;
                end
                T_HOLD:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        m_data_reg  <= {2'b00, dres.angle_x, dres.angle_y, dres.mag,
                                        sres.angle_x, sres.angle_y, sres.mag,
                                        cm1_ext[9:0], 12'(r_reg - 12'd1)};
                        m_valid_reg <= 1'b1;
                        state_reg   <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ rtl/core/sdgm_checker.sv @@
// --------------------------------------------------------------------------
// sdgm_checker
// port-level checks of the gradient map unit
// --------------------------------------------------------------------------
`include "assert_macros.svh"

module sdgm_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [119:0] m_tdata
);

    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
    `ASSERT_NEXT(a_no_instant_result, s_tvalid && s_tready && !m_tvalid, !m_tvalid)
    `ASSERT_SAME(a_row_interior, m_tvalid, m_tdata[11:0] != 12'd0 && m_tdata[11:0] != 12'hfff)

endmodule

bind straight_diagonal_gradient_map_unit sdgm_checker u_sdgm_checker (.*);

@@ tb/tb_top.sv @@
// --------------------------------------------------------------------------
// tb_top
// self-checking bench for the straight/diagonal gradient map unit
// --------------------------------------------------------------------------
// Raster pixel frames of many sizes are streamed into the unit. A bit-exact
// gradient model built into the bench follows every accepted pixel. Each
// output transfer is compared field by field with the oldest predicted
// result. Stimulus covers directed stripe frames, random frames with noise,
// clamped register values, a 1024-wide row and width/height lowered
// mid-frame. Both stream sides idle at random.
// --------------------------------------------------------------------------
module tb_top;
    import sdgm_pkg::*;

    typedef struct packed {
        logic               fs;
        logic [7:0]         pix;
    } pix_item_t;

    typedef struct packed {
        logic signed [15:0] d_ax;
        logic signed [15:0] d_ay;
        logic [15:0]        d_mag;
        logic signed [15:0] s_ax;
        logic signed [15:0] s_ay;
        logic [15:0]        s_mag;
        logic [9:0]         col;
        logic [11:0]        row;
    } grad_out_t;

    localparam longint CORDIC_TAB [20] = '{2949120, 1740967, 919879, 466945, 234379,
        117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
    localparam int  RANDOM_ITEMS = 700;
    localparam longint CYCLE_LIMIT = 2000000;

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic         cfg_index;
    logic [12:0]  cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [119:0] m_tdata;

    pix_item_t pixel_queue[$];
    grad_out_t grad_expect_q[$];
    int        errors;
    int        results_seen;
    int        pixels_taken;
    int        send_idle_pct;
    int        recv_stall_pct;
    logic      hold_on;
    longint    cycles;

    // gradient model state
    logic [7:0] store_up [1024];
    logic [7:0] store_mid [1024];
    logic [7:0] win [3][3];
    int         m_row;
    int         m_col;
    int         m_width;
    int         m_height;

    straight_diagonal_gradient_map_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint shr_tz(longint v, int s);
        if (v < 0)
            return -((-v) >>> s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint res;
        longint bitv;
        res = 0;
        bitv = longint'(1) << 62;
        while (bitv > v)
            bitv = bitv >>> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >>> 1) + bitv;
            end
            else
                res = res >>> 1;
            bitv = bitv >>> 2;
        end
        return res;
    endfunction

    function automatic longint quad_angle(longint a, longint b);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint r;
        x = a << 20;
        y = b << 20;
        z = 0;
        for (int i = 0; i < 20; i++)
        begin
            xs = shr_tz(x, i);
            ys = shr_tz(y, i);
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + CORDIC_TAB[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - CORDIC_TAB[i];
            end
        end
        if (z < 0)
            z = 0;
        if (z > 90 * 65536)
            z = 90 * 65536;
        r = (z + 128) >>> 8;
        return (r > 23040) ? 23040 : r;
    endfunction

    task automatic grad_pair(input int gx, input int gy, output logic [15:0] mag,
                             output logic [15:0] ay, output logic [15:0] ax);
        longint a;
        longint b;
        longint ang;
        longint vy;
        longint vx;
        if (gx == 0)
            gx = 1;
        if (gy == 0)
            gy = 1;
        a = (gx < 0) ? -gx : gx;
        b = (gy < 0) ? -gy : gy;
        mag = 16'(int_sqrt((a * a + b * b) << 14));
        ang = quad_angle(a, b);
        vy = ang;
        vx = 23040 - ang;
        if ((gx < 0) != (gy < 0))
        begin
            vy = -vy;
            vx = -vx;
        end
        ay = vy[15:0];
        ax = vx[15:0];
    endtask

    task automatic grad_predict(input pix_item_t it);
        int        w;
        int        h;
        int        r;
        int        c;
        grad_out_t e;
        w = (m_width < 3) ? 3 : (m_width > 1024) ? 1024 : m_width;
        h = (m_height < 3) ? 3 : (m_height > 4096) ? 4096 : m_height;
        if (it.fs)
        begin
            m_row = 0;
            m_col = 0;
        end
        if (m_col >= w)
        begin
            m_col = 0;
            m_row++;
        end
        if (m_row >= h)
            m_row = 0;
        r = m_row;
        c = m_col;
        for (int k = 0; k < 3; k++)
        begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = store_up[c];
        win[1][2] = store_mid[c];
        win[2][2] = it.pix;
        store_up[c] = store_mid[c];
        store_mid[c] = it.pix;
        if (r >= 2 && c >= 2)
        begin
            e.row = 12'(r - 1);
            e.col = 10'(c - 1);
            grad_pair(int'(win[1][2]) - int'(win[1][0]), int'(win[2][1]) - int'(win[0][1]),
                      e.s_mag, e.s_ay, e.s_ax);
            grad_pair(int'(win[2][2]) - int'(win[0][0]), int'(win[0][2]) - int'(win[2][0]),
                      e.d_mag, e.d_ay, e.d_ax);
            grad_expect_q.insert(grad_expect_q.size(), e);
        end
        m_col = c + 1;
        if (m_col >= w)
        begin
            m_col = 0;
            m_row = r + 1;
            if (m_row >= h)
                m_row = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
                 results_seen);
    endtask

    // input side: model follows every accepted pixel transfer
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            grad_predict('{fs: s_tuser, pix: s_tdata});
            pixels_taken++;
        end
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                pix_item_t it;
                it = pixel_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= it.pix;
                s_tuser  <= it.fs;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                grad_out_t got;
                grad_out_t want;
                got = m_tdata[117:0];
                if (grad_expect_q.size() == 0)
                begin
                    report_mismatch("unexpected result transfer", 1, 0);
                end
                else
                begin
                    want = grad_expect_q.pop_front();
                    if (got.row !== want.row)
                        report_mismatch("center_row", got.row, want.row);
                    if (got.col !== want.col)
                        report_mismatch("center_col", got.col, want.col);
                    if (got.s_mag !== want.s_mag)
                        report_mismatch("straight_mag", got.s_mag, want.s_mag);
                    if (got.s_ay !== want.s_ay)
                        report_mismatch("straight_angle_y", got.s_ay, want.s_ay);
                    if (got.s_ax !== want.s_ax)
                        report_mismatch("straight_angle_x", got.s_ax, want.s_ax);
                    if (got.d_mag !== want.d_mag)
                        report_mismatch("diag_mag", got.d_mag, want.d_mag);
                    if (got.d_ay !== want.d_ay)
                        report_mismatch("diag_angle_y", got.d_ay, want.d_ay);
                    if (got.d_ax !== want.d_ax)
                        report_mismatch("diag_angle_x", got.d_ax, want.d_ax);
                end
                results_seen++;
            end
            if (hold_on)
                m_tready <= 1'b0;
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("** straight_diagonal_gradient_map_unit: FAILED **");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pixel_queue.size() > 0 || s_tvalid || grad_expect_q.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic cfg_write(input logic idx, input int val);
        wait_drained();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val[12:0];
        if (idx == CFG_IMAGE_WIDTH)
            m_width = val & 'h7ff;
        else
            m_height = val & 'h1fff;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_size(input int w, input int h);
        cfg_write(CFG_IMAGE_WIDTH, w);
        cfg_write(CFG_IMAGE_HEIGHT, h);
    endtask

    // style: 0 random, 1 smooth ramp, 2 stripes
    task automatic push_pixels(input int n, input bit first_fs, input int w, input int style);
        pix_item_t it;
        for (int i = 0; i < n; i++)
        begin
            it.fs = (i == 0) && first_fs;
            case (style)
                1: it.pix = 8'(100 + (i % w) + 2 * (i / w) + $urandom_range(3));
                2: it.pix = ((((i % w) >> 1) ^ ((i / w) >> 1)) & 1) ? 8'd255 : 8'd0;
                default: it.pix = 8'($urandom_range(255));
            endcase
            pixel_queue.insert(pixel_queue.size(), it);
        end
    endtask

    initial
    begin
        int w;
        int h;
        int n;
        int rand_items;
        for (int i = 0; i < 1024; i++)
        begin
            store_up[i] = '0;
            store_mid[i] = '0;
        end
        for (int k = 0; k < 3; k++)
            for (int j = 0; j < 3; j++)
                win[k][j] = '0;
        m_row = 0;
        m_col = 0;
        m_width = 640;
        m_height = 480;
        errors = 0;
        results_seen = 0;
        pixels_taken = 0;
        hold_on = 1'b0;
        cycles = 0;
        send_idle_pct = 30;
        recv_stall_pct = 59;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_wr_data = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset size: a few pixels only, no results yet
        push_pixels(8, 1'b1, 640, 0);

        // directed: stripes give +-255 and zero differences
        set_size(5, 5);
        push_pixels(25, 1'b1, 5, 2);

        // clamped register values
        set_size(0, 0);
        push_pixels(9, 1'b1, 3, 2);
        push_pixels(9, 1'b0, 3, 0);

        // width clamped at the top: one full row of 1024, then width lowered
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_size(2047, 3);
        push_pixels(1025, 1'b1, 1024, 0);
        cfg_write(CFG_IMAGE_WIDTH, 3);
        push_pixels(8, 1'b0, 3, 0);
        send_idle_pct = 30;
        recv_stall_pct = 59;

        // tallest height settings, narrow frame
        set_size(3, 4096);
        push_pixels(18, 1'b1, 3, 0);
        cfg_write(CFG_IMAGE_HEIGHT, 8191);
        push_pixels(15, 1'b1, 3, 0);

        // width and height lowered mid-frame
        set_size(8, 6);
        push_pixels(8 * 3 + 4, 1'b1, 8, 0);
        set_size(4, 3);
        push_pixels(20, 1'b0, 4, 0);

        // receiver holds off while the sender keeps offering
        set_size(6, 6);
        fork
            begin
                hold_on <= 1'b1;
                repeat (400) @(posedge clk);
                hold_on <= 1'b0;
            end
        join_none
        push_pixels(60, 1'b1, 6, 0);

        rand_items = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            if (rand_items < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 30;
                recv_stall_pct = 59;
            end
            else if (rand_items < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 59;
                recv_stall_pct = 30;
            end
            else
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            w = $urandom_range(3, 10);
            h = $urandom_range(3, 8);
            set_size(w, h);
            for (int f = $urandom_range(1, 3); f > 0; f--)
            begin
                if ($urandom_range(9) == 0)
                    n = $urandom_range(1, w * h);
                else
                    n = w * h;
                push_pixels(n, 1'b1, w, $urandom_range(3) == 0 ? 1 : 0);
                rand_items += n;
            end
            if ($urandom_range(4) == 0)
            begin
                n = $urandom_range(1, 2 * w);
                push_pixels(n, 1'b0, w, 0);
                rand_items += n;
            end
        end

        wait_drained();
        $display("pixels taken: %0d, results checked: %0d, mismatches: %0d",
                 pixels_taken, results_seen, errors);
        $display("covered stripe, ramp and random frames, clamped sizes, a 1024-wide row");
        $display("and sizes lowered mid-frame under sender and receiver stalls");
        if (errors == 0 && grad_expect_q.size() == 0)
            $display("** straight_diagonal_gradient_map_unit: PASSED **");
        else
            $display("** straight_diagonal_gradient_map_unit: FAILED **");
        $finish;
    end
endmodule

@@ straight_diagonal_gradient_map_unit.f @@
+incdir+rtl/core
rtl/core/sdgm_pkg.sv
rtl/core/sdgm_ram.sv
rtl/core/sdgm_grad.sv
rtl/core/straight_diagonal_gradient_map_unit.sv
rtl/core/sdgm_checker.sv
tb/tb_top.sv
